@@ sv/tdls_pkg.sv @@
// package for the tridiagonal diffusion line solver
// holds shared types, register indexes and the rounding helpers; no dependencies
package tdls_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COEFF_W = 24;
   localparam int unsigned FRAC_W  = 16;
   localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

   typedef enum logic [0:0] {
      REG_DIFFUSION = 1'b0,
      REG_DECAY     = 1'b1
   } reg_index_type;

   // one classified sample handed from the front to the back
   typedef struct packed {
      logic signed [VALUE_W-1:0] sample;
      logic                      first;
      logic                      last;
   } item_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -64'sh80000000) r = 32'sh80000000;
      else r = v[VALUE_W-1:0];
      return r;
   endfunction

   // (a*b)>>16, round to nearest, ties away from zero; p is the product
   function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] p);
      logic [63:0] m;
      m = p[63] ? (64'd0 - p) : p;
      m = (m + 64'h8000) >> FRAC_W;
      return p[63] ? -$signed(m) : $signed(m);
   endfunction

endpackage

@@ sv/tdls_fifo.sv @@
// short queue between the front and the back of the line solver
// depends on tdls_pkg for the item type
module tdls_fifo
   import tdls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type  slot_ff [2];
   logic      wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_item;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !out_valid) else $error("valid while empty");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1)) else $error("push lost");

endmodule

@@ sv/tdls_front.sv @@
// front of the line solver: accepts samples, counts nodes, marks first and last
// depends on tdls_pkg; forces the final node of an over-long line
module tdls_front
   import tdls_pkg::*;
#(
   parameter int unsigned MAX_LINE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [VALUE_W-1:0] in_sample,
   input  logic                      in_last,
   output logic                      q_valid,
   input  logic                      q_ready,
   output item_type                  q_item
);

   localparam int unsigned CNT_W = $clog2(MAX_LINE + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             last_eff;

   assign last_eff = in_last || (count_ff >= CNT_W'(MAX_LINE - 1));
   assign in_ready = q_ready;
   assign q_valid  = in_valid;
   assign q_item   = '{sample: in_sample, first: (count_ff == '0), last: last_eff};

   always_comb begin
      count_in = count_ff;
      if (in_valid && q_ready) count_in = last_eff ? '0 : count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff < CNT_W'(MAX_LINE))
      else $error("node count beyond line length");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && q_ready && last_eff) |=> (count_ff == '0)) else $error("count not cleared");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && q_ready && !last_eff) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("count not advanced");

endmodule

@@ sv/tdls_ram.sv @@
// generic single-port-write, single-read RAM with registered read data
// no dependencies
module tdls_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ sv/tdls_div.sv @@
// serial restoring divider, one quotient bit per cycle, rounded quotient
// depends on tdls_pkg; numerator magnitude 64 bits, divisor positive 40 bits
module tdls_div
   import tdls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num_mag,
   input  logic [39:0] den,
   output logic        done,
   output logic [63:0] quot
);

   logic [63:0] q_ff, q_in;
   logic [40:0] r_ff, r_in;
   logic [39:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [40:0] trial;

   assign done = done_ff;
   assign quot = q_ff;
   assign trial = {r_ff[39:0], q_ff[63]};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         // adding den/2 up front gives round-half-up on the magnitude
         q_in = num_mag + {25'd0, den[39:1]};
         r_in = '0; d_in = den; n_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

endmodule

@@ sv/tdls_back.sv @@
// back of the line solver: forward elimination per node, then back substitution
// depends on tdls_pkg, tdls_div and tdls_ram
module tdls_back
   import tdls_pkg::*;
#(
   parameter int unsigned MAX_LINE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [COEFF_W-1:0]        diff_coeff,
   input  logic [COEFF_W-1:0]        decay_coeff,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  item_type                  q_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [VALUE_W-1:0] out_value,
   output logic                      out_last
);

   localparam int unsigned AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_DIVC, S_WAITC, S_DIVF, S_WAITF, S_STORE,
      S_RDREQ, S_RDWAIT, S_BACK, S_EMIT, S_EMWAIT, S_OUT
   } state_type;

   state_type state_ff;
   item_type  item_ff;
   logic [AW-1:0] idx_ff, top_ff;
   logic signed [VALUE_W-1:0] pf_ff, pc_ff, cur_c_ff, y_ff, fwd_ff;
   logic signed [63:0] den_ff, num_ff;
   logic signed [63:0] mdc_ff, mdf_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic out_valid_ff, out_last_ff;

   logic div_start, div_done;
   logic [63:0] div_num, div_quot;
   logic [39:0] div_den;
   logic div_neg_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VALUE_W-1:0] f_wdata, c_wdata, f_rdata, c_rdata;

   tdls_div u_div (.clock, .reset, .start(div_start), .num_mag(div_num), .den(div_den),
      .done(div_done), .quot(div_quot));

   tdls_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LINE)) u_fwd (.clock, .wr_en,
      .wr_addr, .wr_data(f_wdata), .rd_addr, .rd_data(f_rdata));
   tdls_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LINE)) u_upc (.clock, .wr_en,
      .wr_addr, .wr_data(c_wdata), .rd_addr, .rd_data(c_rdata));

   logic signed [63:0] d64, m64, base, den_fl, signed_q;
   assign d64 = $signed({40'd0, diff_coeff});
   assign m64 = $signed({40'd0, decay_coeff});

   always_comb begin
      if (item_ff.first && item_ff.last) base = 64'sd65536 + m64;
      else if (item_ff.first || item_ff.last) base = 64'sd65536 + d64 + m64;
      else base = 64'sd65536 + (d64 <<< 1) + m64;
      den_fl = base + (item_ff.first ? 64'sd0 : rnd_q16(mdc_ff));
      if (den_fl < 64'sd1) den_fl = 64'sd1;
      signed_q = div_neg_ff ? -$signed(div_quot) : $signed(div_quot);
   end

   assign q_ready   = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

   assign wr_en   = (state_ff == S_STORE) || (state_ff == S_BACK);
   assign wr_addr = idx_ff;
   assign f_wdata = (state_ff == S_STORE) ? fwd_ff : y_ff;
   assign c_wdata = (state_ff == S_STORE) ? cur_c_ff : c_rdata;
   assign rd_addr = idx_ff;

   always_comb begin
      div_start = 1'b0; div_num = '0; div_den = den_ff[39:0];
      if (state_ff == S_DIVC) begin
         // denominator is registered in this same cycle, so feed it directly
         div_start = 1'b1; div_num = {24'd0, diff_coeff, 16'd0};
         div_den = den_fl[39:0];
      end else if (state_ff == S_DIVF) begin
         div_start = 1'b1;
         div_num = num_ff[63] ? (64'd0 - num_ff) << FRAC_W : num_ff << FRAC_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_valid_ff <= 1'b0;
         idx_ff <= '0; pf_ff <= '0; pc_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               item_ff <= q_item;
               if (q_item.first) begin
                  idx_ff <= '0; pf_ff <= '0; pc_ff <= '0;
               end else idx_ff <= idx_ff + 1'b1;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               mdc_ff <= d64 * $signed({{32{pc_ff[31]}}, pc_ff});
               mdf_ff <= d64 * $signed({{32{pf_ff[31]}}, pf_ff});
               state_ff <= S_DIVC;
            end
            S_DIVC: begin
               den_ff <= den_fl;
               num_ff <= $signed({{32{item_ff.sample[31]}}, item_ff.sample})
                  + (item_ff.first ? 64'sd0 : rnd_q16(mdf_ff));
               div_neg_ff <= 1'b1;
               state_ff <= S_WAITC;
            end
            S_WAITC: if (div_done) begin
               cur_c_ff <= sat32(signed_q);
               state_ff <= S_DIVF;
            end
            S_DIVF: begin
               div_neg_ff <= num_ff[63];
               state_ff <= S_WAITF;
            end
            S_WAITF: if (div_done) begin
               fwd_ff <= sat32(signed_q);
               state_ff <= S_STORE;
            end
            S_STORE: begin
               pf_ff <= fwd_ff; pc_ff <= cur_c_ff;
               if (item_ff.last) begin
                  top_ff <= idx_ff; y_ff <= fwd_ff;
                  if (idx_ff == '0) state_ff <= S_EMIT;
                  else begin
                     idx_ff <= idx_ff - 1'b1; state_ff <= S_RDREQ;
                  end
               end else state_ff <= S_IDLE;
            end
            S_RDREQ: state_ff <= S_RDWAIT;
            S_RDWAIT: begin
               // c_rdata and f_rdata now hold node idx
               y_ff <= sat32($signed({{32{f_rdata[31]}}, f_rdata})
                  - rnd_q16($signed({{32{c_rdata[31]}}, c_rdata}) * $signed({{32{y_ff[31]}}, y_ff})));
               state_ff <= S_BACK;
            end
            S_BACK: begin
               if (idx_ff == '0) state_ff <= S_EMIT;
               else begin
                  idx_ff <= idx_ff - 1'b1; state_ff <= S_RDREQ;
               end
            end
            S_EMIT: state_ff <= S_EMWAIT;
            S_EMWAIT: begin
               out_value_ff <= f_rdata; out_last_ff <= (idx_ff == top_ff);
               out_valid_ff <= 1'b1; state_ff <= S_OUT;
            end
            S_OUT: if (out_ready) begin
               out_valid_ff <= 1'b0;
               if (idx_ff == top_ff) begin
                  idx_ff <= '0; pf_ff <= '0; pc_ff <= '0; state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1; state_ff <= S_EMIT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (state_ff == S_OUT)) else $error("result shown outside output state");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_ready && out_last) |=> (state_ff == S_IDLE))
      else $error("line not closed after last result");

endmodule

@@ sv/tridiagonal_diffusion_line_solver.sv @@
// top level of the tridiagonal diffusion line solver
// depends on tdls_pkg, tdls_front, tdls_fifo and tdls_back
//
// usage: samples of one grid line enter on req_ (tdata = sample_value, tlast = line_end);
// the MAX_LINE-th sample of a line is forced final. a non-final sample yields no
// transaction. after the final sample, solved values leave on rsp_ in ascending node
// order, tlast on the last one. coefficients are written on csr_ while idle
// (index 0 diffusion, 1 decay, other indexes ignored).
// the forward pass of each node is dominated by the 64-step bit-serial divider used
// twice per node (upper coefficient and forward value); back substitution then
// revisits every node, and emission each node too, waiting on receiver stalls.
// the first result follows the back substitution of the whole line.
// reset clears control state and coefficients; buffers are not cleared.
// when rsp_tready is low the result holds and the two-entry queue fills, then
// req_tready drops.
module tridiagonal_diffusion_line_solver
   import tdls_pkg::*;
#(
   parameter int unsigned MAX_LINE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_value [31:0]
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // solved_value [31:0]
   output logic        rsp_tlast,   // run_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic [COEFF_W-1:0] diff_ff, decay_ff;
   logic     fq_valid, fq_ready, bq_valid, bq_ready;
   item_type fq_item, bq_item;

   assign csr_ready = 1'b1;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff <= '0; decay_ff <= '0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_DIFFUSION: diff_ff  <= csr_data;
            REG_DECAY:     decay_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tdls_front #(.MAX_LINE(MAX_LINE)) u_front (.clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_sample($signed(req_tdata)),
      .in_last(req_tlast), .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item));

   tdls_fifo u_fifo (.clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready),
      .in_item(fq_item), .out_valid(bq_valid), .out_ready(bq_ready), .out_item(bq_item));

   logic signed [VALUE_W-1:0] out_value;
   tdls_back #(.MAX_LINE(MAX_LINE)) u_back (.clock, .reset, .diff_coeff(diff_ff),
      .decay_coeff(decay_ff), .q_valid(bq_valid), .q_ready(bq_ready), .q_item(bq_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_value(out_value),
      .out_last(rsp_tlast));

   assign rsp_tdata = out_value;

endmodule

@@ tb/tridiagonal_diffusion_line_solver_tb.sv @@
// testbench for the tridiagonal diffusion line solver
// depends on tdls_pkg and the block; a scoreboard class predicts solved values per line
module tridiagonal_diffusion_line_solver_tb;
   import tdls_pkg::*;

   // predicts the solved line from accepted samples and checks every result
   class line_scoreboard;
      logic [23:0] diffusion;
      logic [23:0] decay;
      int          fwd_buf[64];
      int          upper_buf[64];
      int          nodes;
      int          prev_fwd;
      int          prev_upper;
      logic [31:0] solved_q[$];
      bit          end_q[$];
      int          errors;
      int          results;
      int          lines;

      function new();
         diffusion = 0; decay = 0; nodes = 0; prev_fwd = 0; prev_upper = 0;
         errors = 0; results = 0; lines = 0;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // fixed point product, round half away from zero
      function longint q16_product(longint a, longint b);
         longint p, m;
         p = a * b;
         m = (p < 0) ? -p : p;
         m = (m + 32768) >>> 16;
         return (p < 0) ? -m : m;
      endfunction

      function longint rounded_quotient(longint num, longint den);
         longint m;
         m = (num < 0) ? -num : num;
         m = (m + den / 2) / den;
         return (num < 0) ? -m : m;
      endfunction

      function void set_coeff(reg_index_type idx, logic [23:0] v);
         if (idx == REG_DIFFUSION) diffusion = v;
         else decay = v;
      endfunction

      function void note_sample(logic [31:0] x_bits, bit last_in);
         longint d, mu, x, denom, num, c, y;
         int idx, n;
         bit last;
         d = diffusion; mu = decay;
         x = longint'($signed(x_bits));
         idx = nodes; last = last_in;
         // line too long: the 64th node closes the line
         if (idx >= 63) begin
            idx = 63; last = 1;
         end
         if (idx == 0 && last) denom = 65536 + mu;
         else if (idx == 0 || last) denom = 65536 + d + mu;
         else denom = 65536 + 2 * d + mu;
         if (idx > 0) denom += q16_product(d, prev_upper);
         if (denom < 1) denom = 1;   // denominator floor
         c = -rounded_quotient(d * 65536, denom);
         num = x;
         if (idx > 0) num += q16_product(d, prev_fwd);
         fwd_buf[idx] = int'(clip32(rounded_quotient(num * 65536, denom)));
         upper_buf[idx] = int'(clip32(c));
         prev_fwd = fwd_buf[idx];
         prev_upper = upper_buf[idx];
         if (!last) begin
            nodes = idx + 1;
            return;
         end
         n = idx + 1;
         for (int i = n - 2; i >= 0; i--) begin
            y = longint'(fwd_buf[i]) - q16_product(upper_buf[i], fwd_buf[i+1]);
            fwd_buf[i] = int'(clip32(y));
         end
         for (int i = 0; i < n; i++) begin
            solved_q.push_back(fwd_buf[i]);
            end_q.push_back(i == n - 1);
         end
         nodes = 0; prev_fwd = 0; prev_upper = 0;
         lines++;
      endfunction

      function void check_result(logic [31:0] value, bit run_end);
         logic [31:0] exp_v;
         bit exp_e;
         results++;
         if (solved_q.size() == 0) begin
            $display("%0t: unexpected result value %h last %b", $time, value, run_end);
            errors++;
            return;
         end
         exp_v = solved_q.pop_front();
         exp_e = end_q.pop_front();
         if (value !== exp_v) begin
            $display("%0t: solved_value expected %h actual %h", $time, exp_v, value);
            errors++;
         end
         if (run_end !== exp_e) begin
            $display("%0t: run_end expected %b actual %b", $time, exp_e, run_end);
            errors++;
         end
      endfunction

      function int pending();
         return solved_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // sample_value [31:0]
   logic        req_tlast;   // line_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // solved_value [31:0]
   logic        rsp_tlast;   // run_end
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [23:0] csr_data;

   line_scoreboard sb = new();
   bit             no_idle;   // set during the stretch with no gaps on either side
   int             samples_sent;

   tridiagonal_diffusion_line_solver dut (.*);

   initial clock = 0;
   always #10 clock = ~clock;

   // monitor: every accepted transaction goes to the scoreboard at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // receiver backpressure, ready dropped with a chance of about one in five
   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 21);
   end

   // one register write transaction, only while the block is idle
   task automatic write_coeff(reg_index_type idx, logic [23:0] v);
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_data = v;
      do @(posedge clock); while (!csr_ready);
      sb.set_coeff(idx, v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // one input transaction with a random gap in front of it
   task automatic send_sample(logic [31:0] x, bit last);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 21) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1; req_tdata = x; req_tlast = last;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // wait for every expected result, then for the block to settle
   task automatic drain();
      go_quiet();
      while (sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // mix of extremes, small magnitudes and full range values
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h00000000;
         3: return 32'hFFFFFFFF;
         4, 5: return $urandom_range(32'h0010_0000);
         6: return -$urandom_range(32'h0010_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] pick_coeff();
      case ($urandom_range(5))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(24'h000400));
         default: return 24'($urandom_range(24'h040000));
      endcase
   endfunction

   // random line: mostly short, now and then the full length, where the end may be forced
   task automatic send_random_line();
      int len;
      bit long_line;
      long_line = ($urandom_range(19) == 0);
      len = long_line ? 64 : $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
         send_sample(pick_value(),
                     (i == len - 1) ? (long_line ? 1'($urandom_range(1)) : 1'b1) : 1'b0);
   endtask

   initial begin
      reset = 1; req_tvalid = 0; req_tdata = 0; req_tlast = 0;
      rsp_tready = 0; csr_valid = 0; csr_index = REG_DIFFUSION; csr_data = 0;
      no_idle = 0; samples_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero coefficients, single node line
      send_sample(32'h00012345, 1);
      drain();
      // typical coefficients, one-node, extremes and sign changes
      write_coeff(REG_DIFFUSION, 24'h008000);
      write_coeff(REG_DECAY, 24'h000400);
      send_sample(32'h7FFFFFFF, 1);
      send_sample(32'h80000000, 0);
      send_sample(32'h7FFFFFFF, 0);
      send_sample(32'h00000000, 1);
      send_sample(32'hFFFFFFFF, 0);
      send_sample(32'h00000001, 1);
      drain();
      // both coefficients at their maximum
      write_coeff(REG_DIFFUSION, 24'hFFFFFF);
      write_coeff(REG_DECAY, 24'hFFFFFF);
      send_sample(32'h7FFFFFFF, 0);
      send_sample(32'h80000000, 1);
      drain();
      // strong diffusion, no decay; full length line with line_end never set
      write_coeff(REG_DIFFUSION, 24'h030000);
      write_coeff(REG_DECAY, 24'h000000);
      for (int i = 0; i < 64; i++) send_sample(pick_value(), 0);
      send_sample(32'h00010000, 1);
      drain();

      // random lines, new coefficients every few lines
      for (int phase = 0; phase < 8; phase++) begin
         int start;
         start = samples_sent;
         no_idle = (phase == 3);
         write_coeff(REG_DIFFUSION, pick_coeff());
         write_coeff(REG_DECAY, pick_coeff());
         while (samples_sent - start < 28) send_random_line();
         drain();
      end
      no_idle = 0;

      $display("covered %0d samples in %0d lines, %0d results checked",
               samples_sent, sb.lines, sb.results);
      $display("coefficient sets included zero, maximum and random values");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // timeout guard
   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
